FILE: rtl/stok_pkg.sv
// ============================================================================
// stok_pkg
// Shared types, constants and helpers of the source tokenizer stream core.
// ============================================================================
package stok_pkg;

    localparam int LINE_BITS   = 16;
    localparam int LENGTH_BITS = 16;
    localparam int FIELD_BITS  = 16;
    localparam int KIND_BITS   = 4;
    localparam int MAX_TOKENS  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_BITS    = 2 * FIELD_BITS;

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NL         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_IDENT,
        MODE_STRING,
        MODE_COMMENT
    } mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_SPACE,
        KIND_INT,
        KIND_VARIABLE,
        KIND_FUNCTION,
        KIND_STRING,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_COMMENT,
        KIND_UNKNOWN,
        KIND_END
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [FIELD_BITS-1:0]  length;
        logic [FIELD_BITS-1:0]  line;
    } token_t;

    // Tokens of one input item, oldest in slot 0.
    typedef struct packed {
        logic [1:0]                 count;
        token_t [MAX_TOKENS-1:0]    tok;
    } bundle_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic can_push;
        logic has_item;
    } qstat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_drop_ws(input logic [7:0] c);
        return (c inside {[CH_TAB:CH_CR]}) && (c != CH_NL);
    endfunction

    // Appends one token to a bundle; lengths and lines are cut to the field width.
    function automatic bundle_t emit(input bundle_t b, input kind_t k,
                                     input logic [LENGTH_BITS-1:0] len,
                                     input logic [LINE_BITS-1:0] ln);
        bundle_t r;
        r = b;
        r.tok[r.count].kind   = k;
        r.tok[r.count].length = FIELD_BITS'(len);
        r.tok[r.count].line   = FIELD_BITS'(ln);
        r.count               = r.count + 2'd1;
        return r;
    endfunction

endpackage

FILE: rtl/stok_front.sv
// ============================================================================
// stok_front
// Scanner: takes one byte item per cycle while the queue has room, updates the
// scan state and builds the bundle of tokens that the item causes.
// ============================================================================
module stok_front
    import stok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        carries_char,
    input  logic        end_of_text,
    input  qstat_t      qstat,
    output logic        push,
    output bundle_t     bundle
);

    mode_t                  mode_reg, mode_next;
    logic                   slash_reg, slash_next;
    logic [LENGTH_BITS-1:0] run_reg, run_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic                   take;
    logic                   go_dispatch;
    bundle_t                b;

    // Next scan state and the tokens of this item.
    always_comb
    begin
        mode_next   = mode_reg;
        slash_next  = slash_reg;
        run_next    = run_reg;
        line_next   = line_reg;
        go_dispatch = 1'b0;
        b           = '0;

        if (carries_char)
        begin
            case (mode_next)
                MODE_INT:
                begin
                    if (is_digit(ch))
                    begin
                        if (run_next != '1)
                            run_next = run_next + 1'b1;
                    end
                    else
                    begin
                        b = emit(b, KIND_INT, run_next, line_next);
                        go_dispatch = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_ident_char(ch))
                    begin
                        if (run_next != '1)
                            run_next = run_next + 1'b1;
                    end
                    else
                    begin
                        b = emit(b, (ch == CH_LPAREN) ? KIND_FUNCTION : KIND_VARIABLE,
                                 run_next, line_next);
                        go_dispatch = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (ch == CH_NL)
                    begin
                        if (line_next != '1)
                            line_next = line_next + 1'b1;
                    end
                    else
                    begin
                        b = emit(b, KIND_STRING, LENGTH_BITS'(1), line_next);
                        if (ch == CH_QUOTE)
                            mode_next = MODE_IDLE;
                    end
                end
                MODE_COMMENT:
                begin
                    if (ch != CH_NL)
                    begin
                        if (run_next != '1)
                            run_next = run_next + 1'b1;
                    end
                    else
                    begin
                        b = emit(b, KIND_COMMENT, run_next, line_next);
                        go_dispatch = 1'b1;
                    end
                end
                default:
                begin
                    if (slash_next)
                    begin
                        slash_next = 1'b0;
                        if (ch == CH_SLASH)
                        begin
                            mode_next = MODE_COMMENT;
                            run_next  = LENGTH_BITS'(2);
                        end
                        else
                        begin
                            b = emit(b, KIND_UNKNOWN, LENGTH_BITS'(1), line_next);
                            go_dispatch = 1'b1;
                        end
                    end
                    else
                        go_dispatch = 1'b1;
                end
            endcase

            if (go_dispatch)
            begin
                mode_next = MODE_IDLE;
                run_next  = '0;
                if (ch == CH_NL)
                begin
                    if (line_next != '1)
                        line_next = line_next + 1'b1;
                end
                else if (ch == CH_SPACE)
                    b = emit(b, KIND_SPACE, LENGTH_BITS'(1), line_next);
                else if (is_drop_ws(ch))
                    b = b;
                else if (is_digit(ch))
                begin
                    mode_next = MODE_INT;
                    run_next  = LENGTH_BITS'(1);
                end
                else if (is_alpha(ch))
                begin
                    mode_next = MODE_IDENT;
                    run_next  = LENGTH_BITS'(1);
                end
                else if (ch == CH_QUOTE)
                begin
                    b = emit(b, KIND_STRING, LENGTH_BITS'(1), line_next);
                    mode_next = MODE_STRING;
                end
                else if (ch == CH_LPAREN)
                    b = emit(b, KIND_LPAREN, LENGTH_BITS'(1), line_next);
                else if (ch == CH_RPAREN)
                    b = emit(b, KIND_RPAREN, LENGTH_BITS'(1), line_next);
                else if (ch == CH_SLASH)
                    slash_next = 1'b1;
                else
                    b = emit(b, KIND_UNKNOWN, LENGTH_BITS'(1), line_next);
            end
        end

        if (end_of_text)
        begin
            case (mode_next)
                MODE_INT:     b = emit(b, KIND_INT, run_next, line_next);
                MODE_IDENT:   b = emit(b, KIND_VARIABLE, run_next, line_next);
                MODE_COMMENT: b = emit(b, KIND_COMMENT, run_next, line_next);
                MODE_IDLE:
                begin
                    if (slash_next)
                        b = emit(b, KIND_UNKNOWN, LENGTH_BITS'(1), line_next);
                end
                default:      b = b;
            endcase
            b = emit(b, KIND_END, '0, line_next);
            mode_next  = MODE_IDLE;
            slash_next = 1'b0;
            run_next   = '0;
            line_next  = '0;
        end
    end

    // Handshake and queue write.
    always_comb
    begin
        in_ready = qstat.can_push;
        take     = in_valid && qstat.can_push;
        push     = take && (b.count != 2'd0);
        bundle   = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            slash_reg <= 1'b0;
            run_reg   <= '0;
            line_reg  <= '0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            slash_reg <= slash_next;
            run_reg   <= run_next;
            line_reg  <= line_next;
        end
    end

endmodule

FILE: rtl/stok_queue.sv
// ============================================================================
// stok_queue
// Short first-in first-out queue of token bundles between scanner and
// output stage.
// ============================================================================
module stok_queue
    import stok_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bundle_t  push_data,
    input  logic     pop,
    output bundle_t  head,
    output qstat_t   qstat
);

    bundle_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wptr_reg, rptr_reg;
    logic [QCNT_BITS-1:0]   count_reg, count_next;

    always_comb
    begin
        qstat.can_push = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
        qstat.has_item = (count_reg != '0);
        head           = entry_reg[rptr_reg];
        count_next     = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/stok_back.sv
// ============================================================================
// stok_back
// Output stage: sends the tokens of the queue head one per cycle through a
// registered output while the receiver is ready.
// ============================================================================
module stok_back
    import stok_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bundle_t              head,
    input  qstat_t               qstat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_BITS-1:0]  out_data,
    output logic [KIND_BITS-1:0] out_user,
    output logic                 out_last
);

    logic [1:0]           idx_reg, idx_next;
    logic                 valid_reg;
    logic [OUT_BITS-1:0]  data_reg, data_next;
    logic [KIND_BITS-1:0] user_reg;
    logic                 last_reg, last_next;
    logic                 load;
    token_t               cur;

    always_comb
    begin
        load      = qstat.has_item && (!valid_reg || out_ready);
        cur       = head.tok[idx_reg];
        last_next = (idx_reg == head.count - 2'd1);
        pop       = load && last_next;
        idx_next  = last_next ? 2'd0 : idx_reg + 2'd1;
        data_next = {cur.line, cur.length};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg   <= idx_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
            user_reg <= cur.kind;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;
    assign out_last  = last_reg;

endmodule

FILE: rtl/source_tokenizer_stream_core.sv
// ============================================================================
// source_tokenizer_stream_core
// Streaming tokenizer: one source byte per item in, tokens of kind, length
// and line number out.
// ============================================================================
//
// Channel  Side    Item         tdata            tuser         tlast
// s_*      input   source byte  ch               carries_char  end_of_text
// m_*      output  one token    length, line     token_kind    run_end
//
// The scanner takes one input item per cycle whenever the bundle queue has
// room, and each item yields zero to three tokens that leave one per cycle while m_tready is high.
// Input runs at one item per cycle while items average at most one token;
// otherwise it drops to the token rate. The four-deep queue lets either side
// stall without stopping the other. Reset (rst_n low, asynchronous) returns
// the scanner to idle at line 0 and empties the queue and the output register.
// ============================================================================
module source_tokenizer_stream_core
    import stok_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] ch
    input  logic                 s_tuser,   // [0] carries_char
    input  logic                 s_tlast,   // end_of_text
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_BITS-1:0]  m_tdata,   // [15:0] token_length, [31:16] line_number
    output logic [KIND_BITS-1:0] m_tuser,   // [3:0] token_kind
    output logic                 m_tlast    // run_end
);

    qstat_t   qstat;
    logic     push;
    logic     pop;
    bundle_t  push_bundle;
    bundle_t  head;

    // Front part: byte classification and token formation.
    stok_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .ch           (s_tdata),
        .carries_char (s_tuser),
        .end_of_text  (s_tlast),
        .qstat        (qstat),
        .push         (push),
        .bundle       (push_bundle)
    );

    // Holds the token bundles of items that have been scanned but not sent.
    stok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_bundle),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // Back part: one token per cycle while m_tready is high; the last token of an item carries tlast.
    stok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

FILE: tb/sv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the source tokenizer stream core: source bytes go in
// on the slave stream, and every token that comes out is compared with a
// token list built by a predictor that runs beside the block.
// ============================================================================
module tb_top
    import stok_pkg::*;
();

    // Vertical tab and form feed have no names in the package.
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    localparam int IDLE_PCT    = 32;     // percent of cycles in which a side idles
    localparam int HOLD_CYCLES = 400;    // one long stall of the token receiver
    localparam int STALL_LIMIT = 3000;   // cycles without any handshake before giving up
    localparam int RANDOM_ITEMS = 190;

    // One source item as the sender presents it.
    typedef struct packed {
        logic [7:0] ch;
        logic       has_ch;
        logic       eot;
        logic       drain_first;   // hold this item back until every token is in
    } src_item_t;

    // One expected token.
    typedef struct packed {
        kind_t                 kind;
        logic [FIELD_BITS-1:0] length;
        logic [FIELD_BITS-1:0] line;
        logic                  last;
    } token_exp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'h00;
    logic                 s_tuser = 1'b0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_BITS-1:0]  m_tdata;
    logic [KIND_BITS-1:0] m_tuser;
    logic                 m_tlast;

    src_item_t  source_bytes[$];     // items still to be offered
    token_exp_t expected_tokens[$];  // tokens predicted but not yet received
    token_exp_t item_tokens[$];      // tokens caused by the item being predicted

    // Predictor state: the scanner as the block should hold it.
    mode_t                  scan_st = MODE_IDLE;
    logic                   slash_seen = 1'b0;
    logic [LENGTH_BITS-1:0] run_len = '0;
    logic [LINE_BITS-1:0]   line_no = '0;

    // Counters written with nonblocking assignments, so that every process
    // reads the values from before the clock edge.
    int items_sent = 0;
    int items_taken = 0;
    int tokens_predicted = 0;
    int tokens_seen = 0;

    int errors = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int hold_at = 0;
    int steady_lo = 0;
    int steady_hi = 0;
    bit kind_hit[10];

    wire steady = (items_sent >= steady_lo) && (items_sent < steady_hi);

    source_tokenizer_stream_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] ch
        .s_tuser  (s_tuser),    // [0] carries_char
        .s_tlast  (s_tlast),    // end_of_text
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [15:0] length, [31:16] line
        .m_tuser  (m_tuser),    // [3:0] kind
        .m_tlast  (m_tlast)     // run_end
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic is_num(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    // Records one token at the current line. An item never causes more than
    // MAX_TOKENS tokens; anything beyond that is dropped.
    task automatic note_token(input kind_t k, input logic [LENGTH_BITS-1:0] len);
        token_exp_t t;
        if (item_tokens.size() < MAX_TOKENS)
        begin
            t.kind   = k;
            t.length = FIELD_BITS'(len);
            t.line   = FIELD_BITS'(line_no);
            t.last   = 1'b0;
            item_tokens = {item_tokens, t};
        end
    endtask

    task automatic next_line();
        if (line_no != '1)
            line_no = line_no + 1'b1;
    endtask

    task automatic grow_run();
        if (run_len != '1)
            run_len = run_len + 1'b1;
    endtask

    // A byte seen with no run open: it either forms a one-byte token, opens a
    // run, arms the slash, moves the line count, or is dropped.
    task automatic start_token(input logic [7:0] c);
        if (c == CH_NL)
            next_line();
        else if (c == CH_SPACE)
            note_token(KIND_SPACE, LENGTH_BITS'(1));
        else if ((c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR))
            ;
        else if (is_num(c))
        begin
            scan_st = MODE_INT;
            run_len = LENGTH_BITS'(1);
        end
        else if (is_letter(c))
        begin
            scan_st = MODE_IDENT;
            run_len = LENGTH_BITS'(1);
        end
        else if (c == CH_QUOTE)
        begin
            note_token(KIND_STRING, LENGTH_BITS'(1));
            scan_st = MODE_STRING;
        end
        else if (c == CH_LPAREN)
            note_token(KIND_LPAREN, LENGTH_BITS'(1));
        else if (c == CH_RPAREN)
            note_token(KIND_RPAREN, LENGTH_BITS'(1));
        else if (c == CH_SLASH)
            slash_seen = 1'b1;
        else
            note_token(KIND_UNKNOWN, LENGTH_BITS'(1));
    endtask

    task automatic scan_byte(input logic [7:0] c);
        logic fresh;
        fresh = 1'b1;
        case (scan_st)
            MODE_INT:
                if (is_num(c))
                begin
                    grow_run();
                    fresh = 1'b0;
                end
                else
                    note_token(KIND_INT, run_len);
            MODE_IDENT:
                if (is_letter(c) || is_num(c) || (c == CH_UNDERSCORE))
                begin
                    grow_run();
                    fresh = 1'b0;
                end
                else
                    note_token((c == CH_LPAREN) ? KIND_FUNCTION : KIND_VARIABLE, run_len);
            MODE_STRING:
            begin
                // Inside a string every byte but a newline is a token of its own.
                fresh = 1'b0;
                if (c == CH_NL)
                    next_line();
                else
                begin
                    note_token(KIND_STRING, LENGTH_BITS'(1));
                    if (c == CH_QUOTE)
                        scan_st = MODE_IDLE;
                end
            end
            MODE_COMMENT:
                if (c != CH_NL)
                begin
                    grow_run();
                    fresh = 1'b0;
                end
                else
                    note_token(KIND_COMMENT, run_len);
            default:
                if (slash_seen)
                begin
                    slash_seen = 1'b0;
                    if (c == CH_SLASH)
                    begin
                        scan_st = MODE_COMMENT;
                        run_len = LENGTH_BITS'(2);
                        fresh = 1'b0;
                    end
                    else
                        note_token(KIND_UNKNOWN, LENGTH_BITS'(1));
                end
        endcase
        if (fresh)
        begin
            scan_st = MODE_IDLE;
            run_len = '0;
            start_token(c);
        end
    endtask

    // Works out every token of one accepted item and queues them in order.
    task automatic predict_tokens(input src_item_t it);
        int i;
        item_tokens.delete();
        if (it.has_ch)
            scan_byte(it.ch);
        if (it.eot)
        begin
            // End of text flushes what is open; an open string just ends.
            case (scan_st)
                MODE_INT:     note_token(KIND_INT, run_len);
                MODE_IDENT:   note_token(KIND_VARIABLE, run_len);
                MODE_COMMENT: note_token(KIND_COMMENT, run_len);
                MODE_IDLE:    if (slash_seen) note_token(KIND_UNKNOWN, LENGTH_BITS'(1));
                default:      ;
            endcase
            note_token(KIND_END, '0);
            scan_st    = MODE_IDLE;
            slash_seen = 1'b0;
            run_len    = '0;
            line_no    = '0;
        end
        for (i = 0; i < item_tokens.size(); i++)
        begin
            item_tokens[i].last = (i == item_tokens.size() - 1);
            expected_tokens = {expected_tokens, item_tokens[i]};
        end
        tokens_predicted <= tokens_predicted + item_tokens.size();
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued source items. A new item is put on the bus only
    // when the bus is free or the current item is taken at this edge, so
    // tvalid is never dropped and raised within one step.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        src_item_t nxt;
        logic      took;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            took = s_tvalid && s_tready;
            if (took)
            begin
                nxt.ch          = s_tdata;
                nxt.has_ch      = s_tuser;
                nxt.eot         = s_tlast;
                nxt.drain_first = 1'b0;
                predict_tokens(nxt);
                items_taken <= items_taken + 1;
            end
            if (!s_tvalid || took)
            begin
                // A drain-first item waits until the receiver has every token
                // of what went before it.
                if ((source_bytes.size() != 0) &&
                    (!source_bytes[0].drain_first ||
                     (!took && (tokens_seen == tokens_predicted))) &&
                    (steady || ($urandom_range(0, 99) >= IDLE_PCT)))
                begin
                    nxt = source_bytes.pop_front();
                    s_tvalid   <= 1'b1;
                    s_tdata    <= nxt.ch;
                    s_tuser    <= nxt.has_ch;
                    s_tlast    <= nxt.eot;
                    items_sent <= items_sent + 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted token against the oldest expectation and
    // decides the receiver's readiness, including one long hold-off while the
    // sender keeps offering items so that the block's queue fills up.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        token_exp_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                tokens_seen <= tokens_seen + 1;
                if (m_tuser < 10)
                    kind_hit[m_tuser] = 1'b1;
                if (expected_tokens.size() == 0)
                begin
                    $error("token with none expected: kind %0d length %0d line %0d",
                           m_tuser, m_tdata[15:0], m_tdata[31:16]);
                    errors++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("token_kind: expected %0d, got %0d", want.kind, m_tuser);
                        errors++;
                    end
                    if (m_tdata[15:0] !== want.length)
                    begin
                        $error("token_length: expected %0d, got %0d",
                               want.length, m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[31:16] !== want.line)
                    begin
                        $error("line_number: expected %0d, got %0d", want.line, m_tdata[31:16]);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("run_end: expected %0d, got %0d", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (!hold_done && (items_sent >= hold_at))
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: the run is stuck if neither side moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("source_tokenizer_stream_core: mismatch");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] c, input logic eot, input logic drain);
        src_item_t it;
        it.ch          = c;
        it.has_ch      = 1'b1;
        it.eot         = eot;
        it.drain_first = drain;
        source_bytes   = {source_bytes, it};
    endtask

    // An item with no byte; ch carries junk that the block must ignore.
    task automatic add_empty(input logic eot);
        src_item_t it;
        it.ch          = 8'($urandom_range(0, 255));
        it.has_ch      = 1'b0;
        it.eot         = eot;
        it.drain_first = 1'b0;
        source_bytes   = {source_bytes, it};
    endtask

    function automatic logic [7:0] pick_letter();
        int k;
        k = $urandom_range(0, 51);
        return (k < 26) ? 8'("A" + k) : 8'("a" + k - 26);
    endfunction

    function automatic logic [7:0] pick_name_char();
        int k;
        k = $urandom_range(0, 62);
        if (k < 52)
            return pick_letter();
        else if (k < 62)
            return 8'("0" + k - 52);
        return CH_UNDERSCORE;
    endfunction

    // One random source text: mostly well-formed fragments with random
    // content, plus noise, and closed by an end-of-text item.
    task automatic add_text();
        int frags;
        int f;
        int k;
        logic [7:0] c;
        frags = $urandom_range(1, 10);
        for (f = 0; f < frags; f++)
        begin
            case ($urandom_range(0, 13))
                0, 1:
                begin
                    add_byte(pick_letter(), 1'b0, 1'b0);
                    for (k = $urandom_range(0, 5); k > 0; k--)
                        add_byte(pick_name_char(), 1'b0, 1'b0);
                    if ($urandom_range(0, 1))
                        add_byte(CH_LPAREN, 1'b0, 1'b0);
                end
                2:
                    for (k = $urandom_range(1, 4); k > 0; k--)
                        add_byte(8'("0" + $urandom_range(0, 9)), 1'b0, 1'b0);
                3:
                begin
                    add_byte(CH_QUOTE, 1'b0, 1'b0);
                    for (k = $urandom_range(0, 4); k > 0; k--)
                    begin
                        c = 8'($urandom_range(0, 255));
                        add_byte((c == CH_QUOTE) ? CH_NL : c, 1'b0, 1'b0);
                    end
                    if ($urandom_range(0, 3) != 0)
                        add_byte(CH_QUOTE, 1'b0, 1'b0);
                end
                4:
                begin
                    add_byte(CH_SLASH, 1'b0, 1'b0);
                    add_byte(CH_SLASH, 1'b0, 1'b0);
                    for (k = $urandom_range(0, 4); k > 0; k--)
                    begin
                        c = 8'($urandom_range(0, 255));
                        add_byte((c == CH_NL) ? CH_SPACE : c, 1'b0, 1'b0);
                    end
                    if ($urandom_range(0, 3) != 0)
                        add_byte(CH_NL, 1'b0, 1'b0);
                end
                5:  add_byte(CH_SPACE, 1'b0, 1'b0);
                6:  add_byte(CH_NL, 1'b0, 1'b0);
                7:
                begin
                    k = $urandom_range(0, 3);
                    add_byte((k == 0) ? CH_TAB : (k == 1) ? CH_VT : (k == 2) ? CH_FF : CH_CR,
                             1'b0, 1'b0);
                end
                8:  add_byte($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN, 1'b0, 1'b0);
                9:  add_byte(CH_SLASH, 1'b0, 1'b0);
                10: add_byte(CH_UNDERSCORE, 1'b0, 1'b0);
                11: add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                12: add_empty(1'b0);
                default:
                    add_byte($urandom_range(0, 3) ? 8'($urandom_range(128, 255)) : 8'h00,
                             1'b0, 1'b0);
            endcase
        end
        case ($urandom_range(0, 2))
            0:       add_empty(1'b1);
            1:       add_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            default: add_byte(pick_name_char(), 1'b1, 1'b0);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int i;
        int rand_start;
        int kinds;

        // Directed text: integer, space, an identifier that becomes a
        // function, parentheses, a string holding a newline and a high byte,
        // a lone slash, a comment of odd bytes, an underscore that opens
        // nothing, NUL and high bytes outside strings, the dropped whitespace
        // bytes, and an identifier flushed by the end of the text.
        add_byte("0", 1'b0, 1'b0);
        add_byte("9", 1'b0, 1'b0);
        add_byte(CH_SPACE, 1'b0, 1'b0);
        add_byte("a", 1'b0, 1'b0);
        add_byte(CH_UNDERSCORE, 1'b0, 1'b0);
        add_byte("Z", 1'b0, 1'b0);
        add_byte(CH_LPAREN, 1'b0, 1'b0);
        add_byte(CH_RPAREN, 1'b0, 1'b0);
        add_byte(CH_QUOTE, 1'b0, 1'b0);
        add_byte(CH_NL, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(CH_QUOTE, 1'b0, 1'b0);
        add_byte(CH_SLASH, 1'b0, 1'b0);
        add_byte("x", 1'b0, 1'b0);
        add_byte(CH_SLASH, 1'b0, 1'b0);
        add_byte(CH_SLASH, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(CH_NL, 1'b0, 1'b0);
        add_byte(CH_UNDERSCORE, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(CH_TAB, 1'b0, 1'b0);
        add_byte(CH_VT, 1'b0, 1'b0);
        add_byte(CH_FF, 1'b0, 1'b0);
        add_byte(CH_CR, 1'b0, 1'b0);
        add_empty(1'b0);
        add_byte("z", 1'b1, 1'b0);
        // A bare end, then, once every earlier token is back, a slash left
        // pending at the end of a text.
        add_empty(1'b1);
        add_byte(CH_SLASH, 1'b1, 1'b1);

        // Random texts. The receiver's long hold-off falls early in this part
        // and a stretch without idling on either side follows it.
        rand_start = source_bytes.size();
        hold_at    = rand_start + 20;
        steady_lo  = rand_start + 90;
        steady_hi  = rand_start + 190;
        while (source_bytes.size() < rand_start + RANDOM_ITEMS)
            add_text();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while ((source_bytes.size() != 0) || s_tvalid)
            @(posedge clk);
        while (tokens_seen < tokens_predicted)
            @(posedge clk);
        // Keep running so that any surplus token shows up.
        repeat (20) @(posedge clk);

        if (expected_tokens.size() != 0)
        begin
            $error("%0d expected tokens never arrived", expected_tokens.size());
            errors++;
        end

        kinds = 0;
        for (i = 0; i < 10; i++)
            kinds += kind_hit[i];
        $display("Scanned %0d source items into %0d tokens, %0d of 10 token kinds seen.",
                 items_taken, tokens_seen, kinds);
        $display("The run held the receiver off for %0d cycles and drained once mid-stream.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("source_tokenizer_stream_core: match");
        else
            $display("source_tokenizer_stream_core: mismatch");
        $finish;
    end

endmodule

FILE: files.f
rtl/stok_pkg.sv
rtl/stok_front.sv
rtl/stok_queue.sv
rtl/stok_back.sv
rtl/source_tokenizer_stream_core.sv
tb/sv/tb_top.sv
